### rtl/button_debounce_press_hold_assert.svh
// Assertion macros for the checker of the button debounce block.
`ifndef BUTTON_DEBOUNCE_PRESS_HOLD_ASSERT_SVH
`define BUTTON_DEBOUNCE_PRESS_HOLD_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BDPH_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("button debounce check failed");

// The consequent must hold in the cycle after the antecedent.
`define BDPH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("button debounce check failed");

`endif

### rtl/bdph_pkg.sv
// Types, codes and defaults shared by the button debounce block and its checker.
`default_nettype none

package bdph_pkg;

    localparam int NUM_BUTTONS_DEF = 3;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam int CFG_W      = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int RAW_W      = 3;
    localparam int SEL_W      = 2;
    localparam int MODE_INDEX = 2;

    localparam logic [CFG_ADDR_W-1:0] CFG_DEBOUNCE    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_HOLD_NORMAL = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_HOLD_MODE   = 2'd2;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST    = 16'd50;
    localparam logic [CFG_W-1:0] HOLD_NORMAL_RST = 16'd500;
    localparam logic [CFG_W-1:0] HOLD_MODE_RST   = 16'd2000;

    typedef enum logic [1:0] {
        ST_IDLE     = 2'd0,
        ST_PRESSED  = 2'd1,
        ST_HELD     = 2'd2,
        ST_RELEASED = 2'd3
    } t_btn_state;

    typedef enum logic {
        CMD_TICK  = 1'b0,
        CMD_QUERY = 1'b1
    } t_cmd;

endpackage

`default_nettype wire

### rtl/button_debounce_press_hold.sv
// A result is registered and appears on the master side in the cycle after its input transaction.
// Throughput: one transaction per cycle; the input is stalled only while the result
// register is full and the master side is not ready.
// Reset (synchronous, active low) sets all buttons idle with counters and last levels
// at zero, and loads debounce 50, hold 500 and mode hold 2000 ticks.
`default_nettype none

module button_debounce_press_hold
    import bdph_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_W-1:0]      i_cfg_data,
    input  wire logic                  i_s_tvalid,
    output      logic                  o_s_tready,
    // [2:0] raw_levels, [4:3] button, [7:5] zero
    input  wire logic [7:0]            i_s_tdata,
    // [0] command
    input  wire logic                  i_s_tuser,
    output      logic                  o_m_tvalid,
    input  wire logic                  i_m_tready,
    // [1:0] state_open, [3:2] state_close, [5:4] state_mode, [6] released_seen, [7] zero
    output      logic [7:0]            o_m_tdata
);

    localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
    localparam int EXT_W = (NUM_BUTTONS > RAW_W) ? NUM_BUTTONS : RAW_W;

    logic [CFG_W-1:0] r_debounce;
    logic [CFG_W-1:0] r_hold_normal;
    logic [CFG_W-1:0] r_hold_mode;

    logic                   r_last   [NUM_BUTTONS];
    t_btn_state             r_state  [NUM_BUTTONS];
    logic [COUNT_WIDTH-1:0] r_stable [NUM_BUTTONS];
    logic [COUNT_WIDTH-1:0] r_press  [NUM_BUTTONS];

    logic                   n_last   [NUM_BUTTONS];
    t_btn_state             n_state  [NUM_BUTTONS];
    logic [COUNT_WIDTH-1:0] n_stable [NUM_BUTTONS];
    logic [COUNT_WIDTH-1:0] n_press  [NUM_BUTTONS];

    logic       r_out_valid;
    logic [7:0] r_out_data;
    logic [7:0] n_out_data;
    logic       n_released;

    logic             s_accept;
    t_cmd             s_cmd;
    logic [RAW_W-1:0] s_raw;
    logic [SEL_W-1:0] s_sel;
    logic [EXT_W-1:0] s_raw_ext;
    logic [1:0]       s_out_state [3];

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign s_cmd      = t_cmd'(i_s_tuser);
    assign s_raw      = i_s_tdata[2:0];
    assign s_sel      = i_s_tdata[4:3];
    // Buttons beyond the three pins always see a low level.
    assign s_raw_ext  = EXT_W'(s_raw);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce    <= DEBOUNCE_RST;
            r_hold_normal <= HOLD_NORMAL_RST;
            r_hold_mode   <= HOLD_MODE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_DEBOUNCE:    r_debounce    <= i_cfg_data;
                CFG_HOLD_NORMAL: r_hold_normal <= i_cfg_data;
                CFG_HOLD_MODE:   r_hold_mode   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        logic                   level;
        logic                   active;
        logic [COUNT_WIDTH-1:0] pc;
        logic [COUNT_WIDTH-1:0] sc;
        logic [CFG_W-1:0]       hold;
        level  = 1'b0;
        active = 1'b0;
        pc     = '0;
        sc     = '0;
        hold   = '0;
        n_released = 1'b0;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            n_last[i]   = r_last[i];
            n_state[i]  = r_state[i];
            n_stable[i] = r_stable[i];
            n_press[i]  = r_press[i];
            if (s_accept && s_cmd == CMD_TICK) begin
                level  = s_raw_ext[i];
                pc     = (&r_press[i]) ? r_press[i] : r_press[i] + 1'b1;
                sc     = (level != r_last[i]) ? '0 :
                         ((&r_stable[i]) ? r_stable[i] : r_stable[i] + 1'b1);
                hold   = (i == MODE_INDEX) ? r_hold_mode : r_hold_normal;
                active = (r_state[i] == ST_PRESSED) || (r_state[i] == ST_HELD);
                if (CMP_W'(sc) > CMP_W'(r_debounce)) begin
                    if (level != active) begin
                        if (level) begin
                            n_state[i] = ST_PRESSED;
                            pc         = '0;
                        end else begin
                            n_state[i] = ST_RELEASED;
                        end
                    end else if (r_state[i] == ST_PRESSED &&
                                 CMP_W'(pc) >= CMP_W'(hold)) begin
                        n_state[i] = ST_HELD;
                    end
                end
                n_last[i]   = level;
                n_stable[i] = sc;
                n_press[i]  = pc;
            end else if (s_accept && s_cmd == CMD_QUERY) begin
                if (int'(s_sel) == i && r_state[i] == ST_RELEASED) begin
                    n_state[i] = ST_IDLE;
                    n_released = 1'b1;
                end
            end
        end
    end

    // Buttons that do not exist report the idle code.
    for (genvar j = 0; j < 3; j++) begin : g_out
        if (j < NUM_BUTTONS) begin : g_present
            assign s_out_state[j] = n_state[j];
        end else begin : g_absent
            assign s_out_state[j] = ST_IDLE;
        end
    end

    assign n_out_data = {1'b0, n_released, s_out_state[2], s_out_state[1], s_out_state[0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                r_last[i]   <= 1'b0;
                r_state[i]  <= ST_IDLE;
                r_stable[i] <= '0;
                r_press[i]  <= '0;
            end
        end else begin
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                r_last[i]   <= n_last[i];
                r_state[i]  <= n_state[i];
                r_stable[i] <= n_stable[i];
                r_press[i]  <= n_press[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_out_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

`default_nettype wire

### rtl/bdph_checker.sv
// Port-level checker for the button debounce block, bound to its top level.
`default_nettype none
`include "button_debounce_press_hold_assert.svh"

module bdph_checker
    import bdph_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_cfg_we,
    input wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input wire logic [CFG_W-1:0]      i_cfg_data,
    input wire logic                  i_s_tvalid,
    input wire logic                  o_s_tready,
    input wire logic                  i_s_tuser,
    input wire logic                  o_m_tvalid,
    input wire logic                  i_m_tready,
    input wire logic [7:0]            o_m_tdata
);

    logic s_acc;
    logic s_cfg_seen;
    logic s_query_ok;

    assign s_acc      = i_s_tvalid && o_s_tready;
    assign s_cfg_seen = i_cfg_we && (i_cfg_addr == CFG_DEBOUNCE) && (i_cfg_data == '0);

    // A cleared release must show at least one button as idle in the same result.
    assign s_query_ok = !o_m_tdata[6] ||
                        (o_m_tdata[1:0] == ST_IDLE) ||
                        (o_m_tdata[3:2] == ST_IDLE) || (o_m_tdata[5:4] == ST_IDLE);

    `BDPH_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, o_m_tvalid && !i_m_tready,
        o_m_tvalid && $stable(o_m_tdata))
    `BDPH_ASSERT_NEXT(a_accept_gives_result, i_clk, i_rst_n, s_acc, o_m_tvalid)
    `BDPH_ASSERT_NEXT(a_tick_no_release, i_clk, i_rst_n,
        s_acc && (i_s_tuser == CMD_TICK), !o_m_tdata[6] && !o_m_tdata[7])
    `BDPH_ASSERT_NEXT(a_query_clears, i_clk, i_rst_n,
        s_acc && (i_s_tuser == CMD_QUERY) && !s_cfg_seen, s_query_ok)

endmodule

bind button_debounce_press_hold bdph_checker u_bdph_checker (.*);

`default_nettype wire
